// File: rtl/assert_macros.svh
// Assertion macros used by the K-line init state machine (kfbi_seq).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// prop must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: prop");

// cond in one cycle implies prop in the next
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed: cond |=> prop");

`else

`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

// File: rtl/kfbi_pkg.sv
// Types and constants of the K-line five-baud init sequencer.
package kfbi_pkg;

   typedef enum logic [13:0] {
      PH_IDLE     = 14'b00_0000_0000_0001,
      PH_LINEHIGH = 14'b00_0000_0000_0010,
      PH_WAKE     = 14'b00_0000_0000_0100,
      PH_DLY60    = 14'b00_0000_0000_1000,
      PH_SYNC     = 14'b00_0000_0001_0000,
      PH_DLY5     = 14'b00_0000_0010_0000,
      PH_KEY1     = 14'b00_0000_0100_0000,
      PH_KEY2     = 14'b00_0000_1000_0000,
      PH_DLY25    = 14'b00_0001_0000_0000,
      PH_ECHO     = 14'b00_0010_0000_0000,
      PH_ADDR     = 14'b00_0100_0000_0000,
      PH_OK       = 14'b00_1000_0000_0000,
      PH_TMO      = 14'b01_0000_0000_0000,
      PH_BAD      = 14'b10_0000_0000_0000
   } phase_type;

   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_TICK  = 2'd1;
   localparam logic [1:0] ACT_BYTE  = 2'd2;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_BUSY     = 3'd1;
   localparam logic [2:0] ST_OK       = 3'd2;
   localparam logic [2:0] ST_TIMEOUT  = 3'd3;
   localparam logic [2:0] ST_MISMATCH = 3'd4;

   localparam logic [2:0] CSR_WAKE_ADDRESS  = 3'd0;
   localparam logic [2:0] CSR_BIT_TIME_MS   = 3'd1;
   localparam logic [2:0] CSR_IDLE_MS       = 3'd2;
   localparam logic [2:0] CSR_SYNC_TIMEOUT  = 3'd3;
   localparam logic [2:0] CSR_KEY_TIMEOUT   = 3'd4;
   localparam logic [2:0] CSR_REPLY_TIMEOUT = 3'd5;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 12;

   localparam logic [11:0] DLY60_MS  = 12'd60;
   localparam logic [11:0] DLY5_MS   = 12'd5;
   localparam logic [11:0] DLY25_MS  = 12'd25;
   localparam logic [3:0]  WAKE_BITS = 4'd10;
   localparam logic [3:0]  DATA_BITS = 4'd8;

   typedef struct packed {
      logic [7:0]  wake_address;
      logic [9:0]  bit_time_ms;
      logic [11:0] idle_ms;
      logic [9:0]  sync_timeout_ms;
      logic [9:0]  key_timeout_ms;
      logic [9:0]  reply_timeout_ms;
   } cfg_type;

   // packed LSB last: line_level lands in bit 0
   typedef struct packed {
      logic [7:0] address_value;
      logic [7:0] key_two;
      logic [7:0] key_one;
      logic [7:0] sync_value;
      logic [2:0] status;
      logic [7:0] tx_byte;
      logic       tx_valid;
      logic       raw_mode;
      logic       line_level;
   } result_type;

   localparam int unsigned RSP_DATA_W = 48;

endpackage

// File: rtl/kline_five_baud_init_top.sv
// Top level of the K-line five-baud initialization sequencer.
//
//   channel  | direction | handshake             | payload
//   req      | in        | req_tvalid/req_tready | tuser action, tdata rx_byte
//   rsp      | out       | rsp_tvalid/rsp_tready | tdata status and captured bytes
//   csr      | in        | csr_valid/csr_ready   | csr_index, csr_data
//
// One request per cycle while req_tready is high; its response is registered and shows in the next cycle.
// req_tready drops only while a response waits and rsp_tready is low.
// Reset (synchronous) returns the sequencer to idle and the registers to defaults.
// csr_ready is always high; writes to unused indexes are dropped.
module kline_five_baud_init_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [1:0]                           req_tuser,   // action
   input  logic [7:0]                           req_tdata,   // rx_byte
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // line_level, raw_mode, tx_valid, tx_byte[7:0], status[2:0], sync_value[7:0],
   // key_one[7:0], key_two[7:0], address_value[7:0], zero pad
   output logic [kfbi_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [kfbi_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [kfbi_pkg::CSR_DATA_W-1:0]      csr_data
);
   import kfbi_pkg::*;

   cfg_type    cfg;
   result_type result;
   logic       room;
   logic       take;

   assign req_tready = room;
   assign take       = req_tvalid && room;

   kfbi_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   kfbi_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .action  (req_tuser),
      .rx_byte (req_tdata),
      .cfg     (cfg),
      .result  (result)
   );

   kfbi_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (take),
      .result     (result),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: rtl/kfbi_csr.sv
// Configuration register file of the K-line init sequencer.
module kfbi_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [kfbi_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [kfbi_pkg::CSR_DATA_W-1:0]     csr_data,
   output kfbi_pkg::cfg_type                   cfg
);
   import kfbi_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_WAKE_ADDRESS:  cfg_in.wake_address     = csr_data[7:0];
            CSR_BIT_TIME_MS:   cfg_in.bit_time_ms      = csr_data[9:0];
            CSR_IDLE_MS:       cfg_in.idle_ms          = csr_data[11:0];
            CSR_SYNC_TIMEOUT:  cfg_in.sync_timeout_ms  = csr_data[9:0];
            CSR_KEY_TIMEOUT:   cfg_in.key_timeout_ms   = csr_data[9:0];
            CSR_REPLY_TIMEOUT: cfg_in.reply_timeout_ms = csr_data[9:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wake_address     <= 8'd136;
         cfg_ff.bit_time_ms      <= 10'd200;
         cfg_ff.idle_ms          <= 12'd1500;
         cfg_ff.sync_timeout_ms  <= 10'd300;
         cfg_ff.key_timeout_ms   <= 10'd20;
         cfg_ff.reply_timeout_ms <= 10'd50;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/kfbi_seq.sv
// Init sequence state machine: phase, timers, held byte and captured bytes.
`include "assert_macros.svh"

module kfbi_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   take,
   input  logic [1:0]             action,
   input  logic [7:0]             rx_byte,
   input  kfbi_pkg::cfg_type      cfg,
   output kfbi_pkg::result_type   result
);
   import kfbi_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [11:0] ms_timer_ff, ms_timer_in;
   logic [3:0]  bit_index_ff, bit_index_in;
   logic        held_valid_ff, held_valid_in;
   logic [7:0]  held_byte_ff, held_byte_in;
   logic [7:0]  echo_ff, echo_in;
   logic [7:0]  cap0_ff, cap0_in;
   logic [7:0]  cap1_ff, cap1_in;
   logic [7:0]  cap2_ff, cap2_in;
   logic [7:0]  cap3_ff, cap3_in;

   logic [11:0] tmr_inc;
   logic [3:0]  bit_inc;
   logic [11:0] limit;
   logic        sent;
   logic        take_req;
   logic [7:0]  take_val;

   assign tmr_inc = ms_timer_ff + 12'd1;
   assign bit_inc = bit_index_ff + 4'd1;

   always_comb begin
      case (phase_ff)
         PH_SYNC:          limit = {2'b0, cfg.sync_timeout_ms};
         PH_KEY1, PH_KEY2: limit = {2'b0, cfg.key_timeout_ms};
         default:          limit = {2'b0, cfg.reply_timeout_ms};
      endcase
   end

   always_comb begin
      phase_in      = phase_ff;
      ms_timer_in   = ms_timer_ff;
      bit_index_in  = bit_index_ff;
      held_valid_in = held_valid_ff;
      held_byte_in  = held_byte_ff;
      echo_in       = echo_ff;
      cap0_in       = cap0_ff;
      cap1_in       = cap1_ff;
      cap2_in       = cap2_ff;
      cap3_in       = cap3_ff;
      sent          = 1'b0;
      take_req      = 1'b0;
      take_val      = rx_byte;

      if (take) begin
         case (action)
            ACT_START: begin
               phase_in      = PH_LINEHIGH;
               ms_timer_in   = '0;
               bit_index_in  = '0;
               held_valid_in = 1'b0;
               held_byte_in  = '0;
               echo_in       = '0;
               cap0_in       = '0;
               cap1_in       = '0;
               cap2_in       = '0;
               cap3_in       = '0;
            end
            ACT_TICK: begin
               ms_timer_in = tmr_inc;
               case (phase_ff)
                  PH_LINEHIGH: begin
                     if (tmr_inc >= cfg.idle_ms) begin
                        phase_in     = PH_WAKE;
                        bit_index_in = '0;
                        ms_timer_in  = '0;
                     end
                  end
                  PH_WAKE: begin
                     if (tmr_inc >= {2'b0, cfg.bit_time_ms}) begin
                        ms_timer_in  = '0;
                        bit_index_in = bit_inc;
                        if (bit_inc >= WAKE_BITS) begin
                           phase_in     = PH_DLY60;
                           bit_index_in = '0;
                        end
                     end
                  end
                  PH_DLY60, PH_DLY5, PH_DLY25: begin
                     if ((phase_ff == PH_DLY60 && tmr_inc >= DLY60_MS) ||
                         (phase_ff == PH_DLY5  && tmr_inc >= DLY5_MS)  ||
                         (phase_ff == PH_DLY25 && tmr_inc >= DLY25_MS)) begin
                        case (phase_ff)
                           PH_DLY60: phase_in = PH_SYNC;
                           PH_DLY5:  phase_in = PH_KEY1;
                           default: begin
                              phase_in = PH_ECHO;
                              echo_in  = ~cap2_ff;
                              sent     = 1'b1;
                           end
                        endcase
                        ms_timer_in   = '0;
                        take_req      = held_valid_ff;
                        take_val      = held_byte_ff;
                        held_valid_in = 1'b0;
                     end
                  end
                  PH_SYNC, PH_KEY1, PH_KEY2, PH_ECHO, PH_ADDR: begin
                     if (tmr_inc >= limit) phase_in = PH_TMO;
                  end
                  default: ms_timer_in = '0;
               endcase
            end
            ACT_BYTE: take_req = 1'b1;
            default: ;
         endcase
      end

      // byte delivery, either fresh or released from the held slot
      if (take_req) begin
         case (phase_in)
            PH_SYNC: begin
               cap0_in = take_val; phase_in = PH_DLY5; ms_timer_in = '0;
            end
            PH_KEY1: begin
               cap1_in = take_val; phase_in = PH_KEY2; ms_timer_in = '0;
            end
            PH_KEY2: begin
               cap2_in = take_val; phase_in = PH_DLY25; ms_timer_in = '0;
            end
            PH_ECHO: begin
               if (take_val == echo_in) begin
                  phase_in = PH_ADDR; ms_timer_in = '0;
               end else begin
                  phase_in = PH_BAD;
               end
            end
            PH_ADDR: begin
               cap3_in = take_val; phase_in = PH_OK;
            end
            PH_DLY60, PH_DLY5, PH_DLY25: begin
               if (!held_valid_in) begin
                  held_valid_in = 1'b1;
                  held_byte_in  = take_val;
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      result               = '0;
      result.raw_mode      = (phase_in == PH_LINEHIGH) || (phase_in == PH_WAKE);
      result.line_level    = 1'b1;
      if (phase_in == PH_WAKE) begin
         if (bit_index_in == 4'd0) begin
            result.line_level = 1'b0;
         end else if (bit_index_in <= DATA_BITS) begin
            result.line_level = cfg.wake_address[3'(bit_index_in - 4'd1)];
         end
      end
      result.tx_valid      = sent;
      result.tx_byte       = sent ? echo_in : 8'd0;
      case (phase_in)
         PH_IDLE: result.status = ST_IDLE;
         PH_OK:   result.status = ST_OK;
         PH_TMO:  result.status = ST_TIMEOUT;
         PH_BAD:  result.status = ST_MISMATCH;
         default: result.status = ST_BUSY;
      endcase
      result.sync_value    = cap0_in;
      result.key_one       = cap1_in;
      result.key_two       = cap2_in;
      result.address_value = cap3_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         ms_timer_ff   <= '0;
         bit_index_ff  <= '0;
         held_valid_ff <= 1'b0;
         held_byte_ff  <= '0;
         echo_ff       <= '0;
         cap0_ff       <= '0;
         cap1_ff       <= '0;
         cap2_ff       <= '0;
         cap3_ff       <= '0;
      end else begin
         phase_ff      <= phase_in;
         ms_timer_ff   <= ms_timer_in;
         bit_index_ff  <= bit_index_in;
         held_valid_ff <= held_valid_in;
         held_byte_ff  <= held_byte_in;
         echo_ff       <= echo_in;
         cap0_ff       <= cap0_in;
         cap1_ff       <= cap1_in;
         cap2_ff       <= cap2_in;
         cap3_ff       <= cap3_in;
      end
   end

   // held slot is only ever occupied during a fixed delay
   `ASSERT_ALWAYS(a_held_in_delay, clock, reset, !held_valid_ff || phase_ff == PH_DLY60 || phase_ff == PH_DLY5 || phase_ff == PH_DLY25)
   `ASSERT_ALWAYS(a_bit_index_range, clock, reset, bit_index_ff < WAKE_BITS)
   `ASSERT_NEXT(a_start_clears, clock, reset, take && action == ACT_START, phase_ff == PH_LINEHIGH && !held_valid_ff && ms_timer_ff == 12'd0)

endmodule

// File: rtl/kfbi_out.sv
// Result register and response handshake of the K-line init sequencer.
module kfbi_out (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  kfbi_pkg::result_type                 result,
   output logic                                 room,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [kfbi_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import kfbi_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign room       = !valid_ff || rsp_tready;
   assign valid_in   = load || (valid_ff && !rsp_tready);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - $bits(result_type))'(0), data_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

endmodule

// File: bench/kline_five_baud_init_top_test.sv
// Self-checking stream testbench for the K-line five-baud init sequencer.
module kline_five_baud_init_top_test;
   import kfbi_pkg::*;

   localparam logic [1:0] ACT_NONE    = 2'd3;   // no-op request, echoes state
   localparam int         CYCLE_LIMIT = 1000000;

   typedef struct packed {
      phase_type   phase;
      logic [11:0] timer;
      logic [3:0]  bit_idx;
      logic        held_v;
      logic [7:0]  held_b;
      logic [7:0]  echo;
      logic [7:0]  sync_b;
      logic [7:0]  key1_b;
      logic [7:0]  key2_b;
      logic [7:0]  addr_b;
   } init_seq_type;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] rx;
   } kline_req_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [1:0]                 req_tuser = ACT_NONE;   // action
   logic [7:0]                 req_tdata = 8'h00;      // rx_byte
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   // line_level, raw_mode, tx_valid, tx_byte, status, sync_value, key_one,
   // key_two, address_value, zero pad
   logic [RSP_DATA_W-1:0]      rsp_tdata;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_W-1:0]     csr_index = CSR_WAKE_ADDRESS;
   logic [CSR_DATA_W-1:0]      csr_data = '0;

   cfg_type        regs;
   init_seq_type   plan_state;   // steers stimulus, advanced as requests are queued
   init_seq_type   live_state;   // advanced as requests are accepted
   kline_req_type  stim_q [$];
   result_type     want_q [$];

   logic        req_fire = 1'b0;
   int          cycle_count = 0;
   int          fail_count = 0;
   int          work_items = 0;
   int          req_total = 0;
   int          rsp_total = 0;
   int          ok_runs = 0;
   int          tmo_runs = 0;
   int          bad_runs = 0;
   int          tx_sends = 0;

   kline_five_baud_init_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------- sequencer prediction ----------------

   function automatic void seq_take_byte(inout init_seq_type s, input logic [7:0] b);
      case (s.phase)
         PH_SYNC: begin
            s.sync_b = b;
            s.phase = PH_DLY5;
            s.timer = '0;
         end
         PH_KEY1: begin
            s.key1_b = b;
            s.phase = PH_KEY2;
            s.timer = '0;
         end
         PH_KEY2: begin
            s.key2_b = b;
            s.phase = PH_DLY25;
            s.timer = '0;
         end
         PH_ECHO: begin
            if (b == s.echo) begin
               s.phase = PH_ADDR;
               s.timer = '0;
            end else begin
               s.phase = PH_BAD;
            end
         end
         PH_ADDR: begin
            s.addr_b = b;
            s.phase = PH_OK;
         end
         PH_DLY60, PH_DLY5, PH_DLY25: begin
            if (!s.held_v) begin
               s.held_v = 1'b1;
               s.held_b = b;
            end
         end
         default: ;
      endcase
   endfunction

   // a byte parked during a fixed delay is consumed as the wait opens
   function automatic void seq_open_wait(inout init_seq_type s, input phase_type nxt);
      s.phase = nxt;
      s.timer = '0;
      if (s.held_v) begin
         s.held_v = 1'b0;
         seq_take_byte(s, s.held_b);
      end
   endfunction

   function automatic logic seq_tick(inout init_seq_type s);
      logic [11:0] limit;
      logic        waiting;
      logic        sent;
      limit = '0;
      waiting = 1'b0;
      sent = 1'b0;
      s.timer = s.timer + 12'd1;
      case (s.phase)
         PH_LINEHIGH: begin
            if (s.timer >= regs.idle_ms) begin
               s.phase = PH_WAKE;
               s.bit_idx = '0;
               s.timer = '0;
            end
         end
         PH_WAKE: begin
            if (s.timer >= 12'(regs.bit_time_ms)) begin
               s.timer = '0;
               s.bit_idx = s.bit_idx + 4'd1;
               if (s.bit_idx >= WAKE_BITS) begin
                  s.phase = PH_DLY60;
                  s.bit_idx = '0;
               end
            end
         end
         PH_DLY60: begin
            if (s.timer >= DLY60_MS) seq_open_wait(s, PH_SYNC);
         end
         PH_DLY5: begin
            if (s.timer >= DLY5_MS) seq_open_wait(s, PH_KEY1);
         end
         PH_DLY25: begin
            if (s.timer >= DLY25_MS) begin
               s.echo = 8'hFF - s.key2_b;
               sent = 1'b1;
               seq_open_wait(s, PH_ECHO);
            end
         end
         PH_SYNC: begin
            limit = 12'(regs.sync_timeout_ms);
            waiting = 1'b1;
         end
         PH_KEY1, PH_KEY2: begin
            limit = 12'(regs.key_timeout_ms);
            waiting = 1'b1;
         end
         PH_ECHO, PH_ADDR: begin
            limit = 12'(regs.reply_timeout_ms);
            waiting = 1'b1;
         end
         default: s.timer = '0;
      endcase
      if (waiting && s.timer >= limit) s.phase = PH_TMO;
      return sent;
   endfunction

   function automatic result_type seq_step(inout init_seq_type s, input logic [1:0] act,
                                           input logic [7:0] rx);
      result_type r;
      logic       sent;
      sent = 1'b0;
      case (act)
         ACT_START: begin
            s = '0;
            s.phase = PH_LINEHIGH;
         end
         ACT_TICK: sent = seq_tick(s);
         ACT_BYTE: seq_take_byte(s, rx);
         default: ;
      endcase
      r = '0;
      r.raw_mode = (s.phase == PH_LINEHIGH || s.phase == PH_WAKE);
      r.line_level = 1'b1;
      if (s.phase == PH_WAKE) begin
         if (s.bit_idx == 4'd0) r.line_level = 1'b0;
         else if (s.bit_idx <= DATA_BITS)
            r.line_level = regs.wake_address[3'(s.bit_idx - 4'd1)];
      end
      case (s.phase)
         PH_IDLE: r.status = ST_IDLE;
         PH_OK:   r.status = ST_OK;
         PH_TMO:  r.status = ST_TIMEOUT;
         PH_BAD:  r.status = ST_MISMATCH;
         default: r.status = ST_BUSY;
      endcase
      r.tx_valid = sent;
      r.tx_byte = sent ? s.echo : 8'h00;
      r.sync_value = s.sync_b;
      r.key_one = s.key1_b;
      r.key_two = s.key2_b;
      r.address_value = s.addr_b;
      return r;
   endfunction

   // ---------------- stimulus ----------------

   // mostly well-formed traffic for the phase the sequencer is in, some noise
   function automatic kline_req_type pick_request(init_seq_type s);
      kline_req_type q;
      int unsigned   roll;
      roll = $urandom_range(99);
      q.rx = 8'($urandom_range(255));
      case (s.phase)
         PH_IDLE, PH_OK, PH_TMO, PH_BAD:
            q.action = roll < 70 ? ACT_START : roll < 85 ? ACT_TICK :
                       roll < 95 ? ACT_BYTE : ACT_NONE;
         PH_LINEHIGH, PH_WAKE:
            q.action = roll < 92 ? ACT_TICK : roll < 96 ? ACT_BYTE :
                       roll < 99 ? ACT_NONE : ACT_START;
         PH_DLY60, PH_DLY5, PH_DLY25:
            q.action = roll < 85 ? ACT_TICK : roll < 97 ? ACT_BYTE :
                       roll < 99 ? ACT_NONE : ACT_START;
         PH_ECHO: begin
            q.action = roll < 88 ? ACT_BYTE : roll < 98 ? ACT_TICK : ACT_NONE;
            if (roll < 80) q.rx = s.echo;
         end
         default:
            q.action = roll < 72 ? ACT_BYTE : roll < 97 ? ACT_TICK :
                       roll < 99 ? ACT_NONE : ACT_START;
      endcase
      return q;
   endfunction

   task automatic offer(input logic [1:0] act, input logic [7:0] rx);
      kline_req_type q;
      logic          settled;
      settled = plan_state.phase inside {PH_IDLE, PH_OK, PH_TMO, PH_BAD};
      if (act == ACT_START || (act == ACT_TICK && !settled) ||
          (act == ACT_BYTE && !settled && !(plan_state.phase inside {PH_LINEHIGH, PH_WAKE})))
         work_items++;
      void'(seq_step(plan_state, act, rx));
      q.action = act;
      q.rx = rx;
      stim_q.push_back(q);
   endtask

   task automatic tick_through(input phase_type p);
      while (plan_state.phase == p) offer(ACT_TICK, 8'h00);
   endtask

   task automatic run_wakeup();
      offer(ACT_START, 8'($urandom_range(255)));
      tick_through(PH_LINEHIGH);
      tick_through(PH_WAKE);
   endtask

   task automatic drain();
      while (stim_q.size() != 0 || req_tvalid || want_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_regs(input cfg_type c);
      logic [CSR_INDEX_W-1:0] idx [6];
      logic [CSR_DATA_W-1:0]  vals [6];
      idx = '{CSR_WAKE_ADDRESS, CSR_BIT_TIME_MS, CSR_IDLE_MS,
              CSR_SYNC_TIMEOUT, CSR_KEY_TIMEOUT, CSR_REPLY_TIMEOUT};
      vals = '{12'(c.wake_address), 12'(c.bit_time_ms), c.idle_ms,
               12'(c.sync_timeout_ms), 12'(c.key_timeout_ms), 12'(c.reply_timeout_ms)};
      for (int i = 0; i < 6; i++) begin
         @(negedge clock);
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data <= vals[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      regs = c;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ---------------- request driver ----------------

   always @(negedge clock) begin : sender
      static int     burst_left = 1;
      static int     gap_left = 0;
      logic          next_valid;
      kline_req_type q;
      next_valid = req_tvalid && !req_fire;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!next_valid) begin
         if (gap_left != 0) begin
            gap_left--;
         end else if (stim_q.size() != 0) begin
            q = stim_q.pop_front();
            req_tuser <= q.action;
            req_tdata <= q.rx;
            next_valid = 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end
      end
      req_tvalid <= next_valid;
   end

   // ---------------- response sink ----------------

   always @(negedge clock) begin : receiver
      static int   hold_left = 0;
      static logic hold_done = 1'b0;
      logic        rdy;
      if (reset) begin
         rdy = 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rdy = 1'b0;
      end else if (!hold_done && rsp_total >= 400 && stim_q.size() > 40) begin
         // long back-pressure while the sender keeps offering
         hold_done = 1'b1;
         hold_left = 300;
         rdy = 1'b0;
      end else begin
         case ((cycle_count >> 7) % 4)
            0:       rdy = 1'b1;
            1:       rdy = 1'($urandom_range(1));
            2:       rdy = ($urandom_range(3) == 0);
            default: rdy = ($urandom_range(7) != 0);
         endcase
      end
      rsp_tready <= rdy;
   end

   // ---------------- checking ----------------

   task automatic report_mismatch(input string msg);
      fail_count++;
      $display("MISMATCH @%0d: %s", cycle_count, msg);
   endtask

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want);
      if (got != want) report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
   endtask

   always @(posedge clock) begin : monitor
      result_type got;
      result_type want;
      logic [2:0] prev_status;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_total++;
            got = result_type'(rsp_tdata[$bits(result_type)-1:0]);
            if (want_q.size() == 0) begin
               report_mismatch($sformatf("response with no request pending, status %0d",
                                         got.status));
            end else begin
               want = want_q.pop_front();
               check_field("line_level", got.line_level, want.line_level);
               check_field("raw_mode", got.raw_mode, want.raw_mode);
               check_field("tx_valid", got.tx_valid, want.tx_valid);
               check_field("tx_byte", got.tx_byte, want.tx_byte);
               check_field("status", got.status, want.status);
               check_field("sync_value", got.sync_value, want.sync_value);
               check_field("key_one", got.key_one, want.key_one);
               check_field("key_two", got.key_two, want.key_two);
               check_field("address_value", got.address_value, want.address_value);
            end
         end
         if (req_tvalid && req_tready) begin
            req_total++;
            want = seq_step(live_state, req_tuser, req_tdata);
            want_q.push_back(want);
            if (want.tx_valid) tx_sends++;
            if (want.status != prev_status) begin
               if (want.status == ST_OK) ok_runs++;
               if (want.status == ST_TIMEOUT) tmo_runs++;
               if (want.status == ST_MISMATCH) bad_runs++;
            end
            prev_status = want.status;
         end
      end else begin
         prev_status = ST_IDLE;
      end
      req_fire = req_tvalid && req_tready && !reset;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TIMEOUT after %0d cycles, %0d responses pending", cycle_count,
                  want_q.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------- test sequence ----------------

   initial begin : stimulus
      cfg_type       c;
      int            target;
      kline_req_type q;
      regs = '{wake_address: 8'd136, bit_time_ms: 10'd200, idle_ms: 12'd1500,
               sync_timeout_ms: 10'd300, key_timeout_ms: 10'd20, reply_timeout_ms: 10'd50};
      plan_state = '0;
      plan_state.phase = PH_IDLE;
      live_state = plan_state;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // idle behavior and restarts under reset defaults
      offer(ACT_NONE, 8'h5A);
      offer(ACT_TICK, 8'h00);
      offer(ACT_BYTE, 8'h00);
      offer(ACT_BYTE, 8'hFF);
      offer(ACT_START, 8'hFF);
      offer(ACT_TICK, 8'hA5);
      offer(ACT_BYTE, 8'hA5);
      offer(ACT_NONE, 8'h00);
      offer(ACT_START, 8'h00);
      offer(ACT_TICK, 8'h00);
      drain();

      // shortest timing: held and dropped bytes, success, timeout, bad echo
      load_regs('{wake_address: 8'h00, bit_time_ms: 10'd1, idle_ms: 12'd1,
                  sync_timeout_ms: 10'd1, key_timeout_ms: 10'd1, reply_timeout_ms: 10'd1});
      run_wakeup();
      offer(ACT_BYTE, 8'h3C);
      offer(ACT_BYTE, 8'hC3);
      tick_through(PH_DLY60);
      offer(ACT_BYTE, 8'h81);
      tick_through(PH_DLY5);
      offer(ACT_BYTE, 8'h00);
      tick_through(PH_DLY25);
      offer(ACT_BYTE, 8'hFF);
      offer(ACT_BYTE, 8'hFF);
      run_wakeup();
      tick_through(PH_DLY60);
      offer(ACT_TICK, 8'h00);
      run_wakeup();
      tick_through(PH_DLY60);
      offer(ACT_BYTE, 8'h55);
      tick_through(PH_DLY5);
      offer(ACT_BYTE, 8'hAA);
      offer(ACT_BYTE, 8'hFF);
      tick_through(PH_DLY25);
      offer(ACT_BYTE, 8'h01);
      drain();

      // random traffic across several small timing settings
      for (int ph = 0; ph < 5; ph++) begin
         c.wake_address = (ph == 2) ? 8'hFF : 8'($urandom_range(255));
         c.bit_time_ms = 10'($urandom_range(1, 3));
         c.idle_ms = 12'($urandom_range(1, 4));
         c.sync_timeout_ms = 10'($urandom_range(1, 8));
         c.key_timeout_ms = 10'($urandom_range(1, 4));
         c.reply_timeout_ms = 10'($urandom_range(1, 6));
         load_regs(c);
         target = work_items + 130;
         while (work_items < target) begin
            q = pick_request(plan_state);
            offer(q.action, q.rx);
         end
         drain();
      end

      // widest wait limits: a full pass with every byte arriving well inside its window
      load_regs('{wake_address: 8'hFF, bit_time_ms: 10'd1, idle_ms: 12'd1,
                  sync_timeout_ms: 10'd1023, key_timeout_ms: 10'd1023,
                  reply_timeout_ms: 10'd1023});
      run_wakeup();
      tick_through(PH_DLY60);
      repeat (12) offer(ACT_TICK, 8'h00);
      offer(ACT_BYTE, 8'($urandom_range(255)));
      tick_through(PH_DLY5);
      repeat (9) offer(ACT_TICK, 8'h00);
      offer(ACT_BYTE, 8'($urandom_range(255)));
      offer(ACT_BYTE, 8'($urandom_range(255)));
      tick_through(PH_DLY25);
      repeat (7) offer(ACT_TICK, 8'h00);
      offer(ACT_BYTE, plan_state.echo);
      offer(ACT_BYTE, 8'($urandom_range(255)));
      drain();

      $display("Covered %0d requests and %0d responses in %0d cycles", req_total,
               rsp_total, cycle_count);
      $display("Init runs: %0d completed, %0d timed out, %0d bad echo, %0d complements sent",
               ok_runs, tmo_runs, bad_runs, tx_sends);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/kfbi_pkg.sv
rtl/kfbi_csr.sv
rtl/kfbi_seq.sv
rtl/kfbi_out.sv
rtl/kline_five_baud_init_top.sv
bench/kline_five_baud_init_top_test.sv
